FILE: src/skaf_pkg.sv
package skaf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegProcessNoise     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMeasurementNoise = 2'd1;

  localparam logic [DataW-1:0] ProcessNoiseReset     = 32'd66;
  localparam logic [DataW-1:0] MeasurementNoiseReset = 32'd65536;

  typedef enum logic [2:0] {
    StIdle,
    StPredict,
    StDivide,
    StMulEst,
    StMulCov,
    StFinish,
    StDone
  } state_e;

endpackage

FILE: src/scalar_kalman_angle_filter.sv
// Scalar Kalman filter for one angle in signed fixed point. Each input transfer carries
// one measured angle; the block predicts the covariance, forms the gain P/(P+R) with a
// restoring divider that yields one quotient bit per cycle, then updates the estimate and
// the covariance through one shared multiplier. When P + Q and R are both zero the
// divider is skipped. The input is stalled from the transfer until the result has been
// taken. Configuration writes are always taken and should only be made while the block
// is idle.
module scalar_kalman_angle_filter #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned GAIN_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [skaf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [skaf_pkg::DataW-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [skaf_pkg::DataW-1:0]  measured_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [skaf_pkg::DataW-1:0]  filtered_angle_o,
  output logic [skaf_pkg::DataW-1:0]         error_variance_o
);

  localparam int unsigned GW   = GAIN_BITS + 1;
  localparam int unsigned CntW = $clog2(GAIN_BITS + 1);
  localparam int unsigned PW   = GAIN_BITS + 35;
  localparam logic [GW-1:0] GainOne = GW'(1) << GAIN_BITS;
  localparam logic [31:0] CovReset = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [34:0] SMax = 35'sd2147483647;
  localparam logic signed [34:0] SMin = -35'sd2147483648;

  skaf_pkg::state_e state_q, state_d;

  logic [31:0]        q_noise_q, r_noise_q;
  logic [31:0]        meas_q;
  logic [31:0]        est_q, est_d;
  logic [31:0]        cov_q, cov_d;
  logic [31:0]        p_q, p_d;
  logic [32:0]        denom_q, denom_d;
  logic [32:0]        rem_q, rem_d;
  logic [GW-1:0]      gain_q, gain_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic signed [PW-1:0] prod_q, prod_d;

  logic [32:0]        p_sum;
  logic [31:0]        p_sat;
  logic [32:0]        denom_c;
  logic               denom_zero;
  logic [33:0]        rem_sh;
  logic               rem_ge;
  logic signed [32:0] innov;
  logic signed [GAIN_BITS+1:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [PW-1:0] step_full;
  logic signed [34:0] est_sum;
  logic [34:0]        cov_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q <= skaf_pkg::ProcessNoiseReset;
      r_noise_q <= skaf_pkg::MeasurementNoiseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        skaf_pkg::RegProcessNoise:     q_noise_q <= cfg_data_i;
        skaf_pkg::RegMeasurementNoise: r_noise_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign p_sum      = {1'b0, cov_q} + {1'b0, q_noise_q};
  assign p_sat      = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
  assign denom_c    = {1'b0, p_sat} + {1'b0, r_noise_q};
  assign denom_zero = (denom_c == 33'd0);

  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, denom_q});

  assign innov = $signed({meas_q[31], meas_q}) - $signed({est_q[31], est_q});

  always_comb begin
    if (state_q == skaf_pkg::StMulEst) begin
      mul_a = $signed({1'b0, gain_q});
      mul_b = innov;
    end else begin
      mul_a = $signed({1'b0, GainOne - gain_q});
      mul_b = $signed({1'b0, p_q});
    end
  end

  assign prod_d = mul_a * mul_b;

  assign step_full = prod_q >>> GAIN_BITS;
  assign est_sum   = $signed({{3{est_q[31]}}, est_q}) + $signed(step_full[34:0]);
  assign cov_full  = prod_q[GAIN_BITS+34:GAIN_BITS];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skaf_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = skaf_pkg::StPredict;
        end
      end
      skaf_pkg::StPredict: begin
        state_d = denom_zero ? skaf_pkg::StMulEst : skaf_pkg::StDivide;
      end
      skaf_pkg::StDivide: begin
        if (cnt_q == CntW'(1)) begin
          state_d = skaf_pkg::StMulEst;
        end
      end
      skaf_pkg::StMulEst: state_d = skaf_pkg::StMulCov;
      skaf_pkg::StMulCov: state_d = skaf_pkg::StFinish;
      skaf_pkg::StFinish: state_d = skaf_pkg::StDone;
      skaf_pkg::StDone: begin
        if (!out_stall_i) begin
          state_d = skaf_pkg::StIdle;
        end
      end
      default: state_d = skaf_pkg::StIdle;
    endcase
  end

  always_comb begin
    p_d     = p_q;
    denom_d = denom_q;
    rem_d   = rem_q;
    gain_d  = gain_q;
    cnt_d   = cnt_q;
    est_d   = est_q;
    cov_d   = cov_q;
    unique case (state_q)
      skaf_pkg::StPredict: begin
        p_d     = p_sat;
        denom_d = denom_c;
        cnt_d   = CntW'(GAIN_BITS);
        if (denom_zero) begin
          gain_d = '0;
          rem_d  = '0;
        end else if ({1'b0, p_sat} == denom_c) begin
          gain_d = GW'(1);
          rem_d  = '0;
        end else begin
          gain_d = '0;
          rem_d  = {1'b0, p_sat};
        end
      end
      skaf_pkg::StDivide: begin
        cnt_d  = cnt_q - CntW'(1);
        gain_d = {gain_q[GW-2:0], rem_ge};
        rem_d  = rem_ge ? 33'(rem_sh - {1'b0, denom_q}) : rem_sh[32:0];
      end
      skaf_pkg::StMulCov: begin
        if (est_sum > SMax) begin
          est_d = 32'h7FFF_FFFF;
        end else if (est_sum < SMin) begin
          est_d = 32'h8000_0000;
        end else begin
          est_d = est_sum[31:0];
        end
      end
      skaf_pkg::StFinish: begin
        cov_d = (|cov_full[34:32]) ? 32'hFFFF_FFFF : cov_full[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skaf_pkg::StIdle;
      est_q   <= '0;
      cov_q   <= CovReset;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      cov_q   <= cov_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      meas_q <= measured_angle_i;
    end
    p_q     <= p_d;
    denom_q <= denom_d;
    rem_q   <= rem_d;
    gain_q  <= gain_d;
    if (state_q == skaf_pkg::StMulEst || state_q == skaf_pkg::StMulCov) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    in_stall_o       = (state_q != skaf_pkg::StIdle);
    out_valid_o      = (state_q == skaf_pkg::StDone);
    filtered_angle_o = est_q;
    error_variance_o = cov_q;
  end

endmodule

FILE: src/skaf_checker.sv
module skaf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [skaf_pkg::DataW-1:0]   filtered_angle_o,
  input logic [skaf_pkg::DataW-1:0]   error_variance_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_angle_o)
      && $stable(error_variance_o))
    else $error("stalled result changed or vanished");

  // No input transfer while a result is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !out_valid_o)
    else $error("input taken while a result is pending");

  // After an input transfer the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("block not busy after an input transfer");

  // A result is presented only while the input side is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result shown while input open");

endmodule

bind scalar_kalman_angle_filter skaf_checker u_skaf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .filtered_angle_o(filtered_angle_o),
  .error_variance_o(error_variance_o)
);

FILE: test/kalman_result_checker.sv
`timescale 1ns / 100ps

module kalman_result_checker #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned GAIN_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [skaf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [skaf_pkg::DataW-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [skaf_pkg::DataW-1:0]  measured_angle_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [skaf_pkg::DataW-1:0]  filtered_angle_i,
  input  logic [skaf_pkg::DataW-1:0]         error_variance_i,
  output int                                 mismatches_o,
  output int                                 backlog_o,
  output int                                 results_o
);

  typedef struct packed {
    logic [skaf_pkg::DataW-1:0] angle;
    logic [skaf_pkg::DataW-1:0] variance;
  } estimate_t;

  localparam longint          AngleMax   = 64'sd2147483647;
  localparam longint          AngleMin   = -64'sd2147483648;
  localparam longint unsigned WordMax    = 64'hFFFF_FFFF;
  localparam int              PrintLimit = 40;

  longint          angle_est;
  longint unsigned covariance;
  longint unsigned process_noise;
  longint unsigned measurement_noise;
  estimate_t       expected_estimates[$];
  estimate_t       want;

  // One filter step on the local copy of the state; returns the expected outputs.
  function automatic estimate_t kalman_update(
      input logic signed [skaf_pkg::DataW-1:0] meas);
    longint unsigned prior;
    longint unsigned denom;
    longint unsigned gain;
    longint          innov;
    longint          next;
    estimate_t       res;
    prior = covariance + process_noise;
    if (prior > WordMax) prior = WordMax;
    denom = prior + measurement_noise;
    gain = (denom == 0) ? 64'd0 : (prior << GAIN_BITS) / denom;
    innov = longint'(meas) - angle_est;
    next = angle_est + ((longint'(gain) * innov) >>> GAIN_BITS);
    if (next > AngleMax) next = AngleMax;
    if (next < AngleMin) next = AngleMin;
    angle_est = next;
    prior = (prior * ((64'd1 << GAIN_BITS) - gain)) >> GAIN_BITS;
    if (prior > WordMax) prior = WordMax;
    covariance = prior;
    res.angle = next[skaf_pkg::DataW-1:0];
    res.variance = covariance[skaf_pkg::DataW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [skaf_pkg::DataW-1:0] got,
                                 input logic [skaf_pkg::DataW-1:0] exp_val);
    if (mismatches_o < PrintLimit) begin
      $display("%t result %0d %s: got %h, expected %h", $realtime, results_o, field, got,
               exp_val);
    end
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_est = 0;
      covariance = 64'd1 << FRAC_BITS;
      process_noise = 64'(skaf_pkg::ProcessNoiseReset);
      measurement_noise = 64'(skaf_pkg::MeasurementNoiseReset);
      expected_estimates.delete();
      backlog_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == skaf_pkg::RegProcessNoise) begin
          process_noise = 64'(cfg_data_i);
        end else if (cfg_index_i == skaf_pkg::RegMeasurementNoise) begin
          measurement_noise = 64'(cfg_data_i);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch("unexpected transfer", filtered_angle_i, '0);
        end else begin
          want = expected_estimates.pop_front();
          if (filtered_angle_i !== want.angle) begin
            report_mismatch("filtered_angle", filtered_angle_i, want.angle);
          end
          if (error_variance_i !== want.variance) begin
            report_mismatch("error_variance", error_variance_i, want.variance);
          end
        end
        results_o++;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_estimates.push_back(kalman_update(measured_angle_i));
      end
      backlog_o = expected_estimates.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FracBits       = 16;
  localparam int unsigned GainBits       = 16;
  localparam int          NumPhases      = 10;
  localparam int          AnglesPerPhase = 113;
  localparam int          MaxWait        = 10;
  localparam int          HoldCycles     = 300;
  localparam int          DrainCycles    = 30;
  localparam int          QuietLimit     = 2000;

  localparam logic [skaf_pkg::CfgIdxW-1:0] RegSpareLow  = 2'd2;
  localparam logic [skaf_pkg::CfgIdxW-1:0] RegSpareHigh = 2'd3;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [skaf_pkg::CfgIdxW-1:0]        cfg_index_i;
  logic [skaf_pkg::DataW-1:0]          cfg_data_i;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [skaf_pkg::DataW-1:0]   measured_angle_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [skaf_pkg::DataW-1:0]   filtered_angle_o;
  logic [skaf_pkg::DataW-1:0]          error_variance_o;

  int mismatches;
  int backlog;
  int results;
  int angles_sent;
  int writes_done;
  int settings_used;

  bit                         send_idle;
  bit                         take_idle;
  bit                         hold_request;
  logic [skaf_pkg::DataW-1:0] track_angle;

  scalar_kalman_angle_filter #(
    .FRAC_BITS (FracBits),
    .GAIN_BITS (GainBits)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .measured_angle_i (measured_angle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_angle_o (filtered_angle_o),
    .error_variance_o (error_variance_o)
  );

  kalman_result_checker #(
    .FRAC_BITS (FracBits),
    .GAIN_BITS (GainBits)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .measured_angle_i (measured_angle_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_angle_i (filtered_angle_o),
    .error_variance_i (error_variance_o),
    .mismatches_o     (mismatches),
    .backlog_o        (backlog),
    .results_o        (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending", quiet, backlog);
        $display("status: fail");
        $finish;
      end
    end
  end

  // When take_idle is set, the receiver waits a drawn number of cycles before each result;
  // it holds off once for a long stretch when asked to.
  initial begin : result_sink
    int wait_left;
    int hold_left;
    wait_left = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      if (out_valid_o && !out_stall_i) begin
        wait_left = take_idle ? $urandom_range(MaxWait, 0) : 0;
      end else if (out_valid_o && wait_left > 0) begin
        wait_left--;
      end
      @(negedge clk_i);
      out_stall_i <= (hold_left > 0) || (wait_left > 0);
    end
  end

  function automatic logic [skaf_pkg::DataW-1:0] draw_noise();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1023, 0);
      3: return $urandom_range(32'h0010_0000, 32'h0000_1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [skaf_pkg::DataW-1:0] draw_angle();
    case ($urandom_range(9, 0))
      0, 1, 2: return $urandom;
      3: begin
        case ($urandom_range(3, 0))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      4, 5: return $urandom_range(32'h01FF_FFFF, 0) - 32'h0100_0000;
      default: begin
        track_angle = track_angle + $urandom_range(2047, 0) - 32'd1024;
        return track_angle + $urandom_range(255, 0) - 32'd128;
      end
    endcase
  endfunction

  task automatic write_register(input logic [skaf_pkg::CfgIdxW-1:0] index,
                                input logic [skaf_pkg::DataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    writes_done++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_angle(input logic [skaf_pkg::DataW-1:0] angle);
    int gap;
    gap = send_idle ? $urandom_range(MaxWait, 0) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_angle_i <= angle;
    do @(posedge clk_i); while (in_stall_o);
    angles_sent++;
  endtask

  // Stops offering angles and lets every pending result and the pipeline tail finish.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (backlog == 0);
    repeat (DrainCycles) @(posedge clk_i);
    settings_used++;
  endtask

  initial begin : stimulus
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    measured_angle_i = '0;
    send_idle = 1'b0;
    take_idle = 1'b0;
    hold_request = 1'b0;
    track_angle = '0;
    angles_sent = 0;
    writes_done = 0;
    settings_used = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_angle(32'h0000_0000);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'hFFFF_FFFF);
    send_angle(32'h0000_0001);

    // Zero measurement noise gives a gain of exactly one.
    drain_results();
    write_register(skaf_pkg::RegMeasurementNoise, '0);
    send_angle(32'h8000_0000);
    send_angle(32'h7FFF_FFFF);

    // Covariance is zero now, so with no process noise the gain denominator is zero.
    drain_results();
    write_register(skaf_pkg::RegProcessNoise, '0);
    send_angle(32'h1234_5678);
    send_angle(32'h8000_0000);

    // Full-scale noise drives the predicted covariance into saturation.
    drain_results();
    write_register(skaf_pkg::RegProcessNoise, '1);
    write_register(skaf_pkg::RegMeasurementNoise, '1);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(32'h0000_0000);

    drain_results();
    write_register(skaf_pkg::RegMeasurementNoise, '0);
    send_angle(32'hDEAD_BEEF);

    drain_results();
    write_register(skaf_pkg::RegProcessNoise, '0);
    write_register(skaf_pkg::RegMeasurementNoise, '1);
    send_angle(32'h4000_0000);
    send_angle(32'hC000_0000);

    // Writes beyond the register list must leave both noise values alone.
    drain_results();
    write_register(RegSpareLow, '1);
    write_register(RegSpareHigh, '1);
    send_angle(32'h0123_4567);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      write_register(skaf_pkg::RegProcessNoise, draw_noise());
      write_register(skaf_pkg::RegMeasurementNoise, draw_noise());
      if ($urandom_range(1, 0) == 1) begin
        write_register(($urandom_range(1, 0) == 1) ? RegSpareLow : RegSpareHigh, $urandom);
      end
      send_idle = (ph != 0) && ($urandom_range(2, 0) != 0);
      take_idle = (ph != 0) && ($urandom_range(2, 0) != 0);
      if (ph == 3) begin
        hold_request = 1'b1;
      end
      repeat (AnglesPerPhase) send_angle(draw_angle());
    end

    drain_results();
    $display("covered %0d angle transfers, %0d results, %0d register writes, %0d settings",
             angles_sent, results, writes_done, settings_used);
    $display("included zero and full-scale noise, a zero gain denominator, spare indexes %s",
             "and a long output hold-off");
    if (mismatches == 0 && backlog == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
